/* hdl/mfvc_pkg.sv */
// mfvc_pkg: widths, codes and types of the magnetometer field validity check
// depends on nothing
`default_nettype none
package mfvc_pkg;

    localparam int FIELD_WIDTH = 18;
    localparam int QUAT_W      = 16;
    localparam int RATIO_W     = 16;
    localparam int AVG_W       = FIELD_WIDTH + 8;
    localparam int LPF_W       = AVG_W + 1;
    localparam int PROD_W      = 2 * QUAT_W;
    localparam int ROT_W       = PROD_W + 2;
    localparam int DEV_W       = FIELD_WIDTH + 16;
    localparam int SQ_W        = 2 * DEV_W;
    localparam int R2_W        = 2 * RATIO_W;
    localparam int ACC_W       = SQ_W + R2_W + 1;
    localparam int B_W         = (DEV_W > R2_W + 1) ? DEV_W : R2_W + 1;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [3:0] CHECK_INTERVAL = 4'd10;
    localparam logic [2:0] ALARM_PERSIST  = 3'd3;
    localparam int         LPF_ALPHA      = 13107;
    localparam logic [CNT_W-1:0] LPF_N    = CNT_W'(15);
    localparam logic [CNT_W-1:0] QUAT_N   = CNT_W'(QUAT_W);
    localparam logic [CNT_W-1:0] ROT_N    = CNT_W'(FIELD_WIDTH);
    localparam logic [CNT_W-1:0] SQ_N     = CNT_W'(DEV_W);
    localparam logic [CNT_W-1:0] R2_N     = CNT_W'(RATIO_W + 1);
    localparam logic [CNT_W-1:0] THR_N    = CNT_W'(R2_W + 1);

    localparam logic [2:0] REG_BE_NORTH    = 3'd0;
    localparam logic [2:0] REG_BE_EAST     = 3'd1;
    localparam logic [2:0] REG_BE_DOWN     = 3'd2;
    localparam logic [2:0] REG_WARN_RATIO  = 3'd3;
    localparam logic [2:0] REG_ERROR_RATIO = 3'd4;

    localparam logic [RATIO_W-1:0] WARN_RATIO_RST  = 16'd205;
    localparam logic [RATIO_W-1:0] ERROR_RATIO_RST = 16'd614;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_WARN  = 2'd2,
        ACT_ERROR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        S_LPF_X, S_LPF_Y, S_LPF_Z,
        S_Q_WW, S_Q_XX, S_Q_YY, S_Q_ZZ, S_Q_XY,
        S_Q_WZ, S_Q_XZ, S_Q_WY, S_Q_YZ, S_Q_WX,
        S_ROT_X0, S_ROT_X1, S_ROT_X2,
        S_ROT_Y0, S_ROT_Y1, S_ROT_Y2,
        S_ROT_Z0, S_ROT_Z1, S_ROT_Z2,
        S_SQ_EX, S_SQ_EY, S_SQ_EZ,
        S_SQ_DX, S_SQ_DY, S_SQ_DZ,
        S_R2_W, S_R2_E,
        S_THR_W, S_THR_E
    } step_t;

endpackage
`default_nettype wire

/* hdl/mfvc_if.sv */
// mfvc_in_if and mfvc_out_if: valid/ready channels for sample and result beats
// depends on mfvc_pkg
`default_nettype none
interface mfvc_in_if;
    logic valid;
    logic ready;
    logic signed [mfvc_pkg::FIELD_WIDTH-1:0] mag_x;
    logic signed [mfvc_pkg::FIELD_WIDTH-1:0] mag_y;
    logic signed [mfvc_pkg::FIELD_WIDTH-1:0] mag_z;
    logic signed [mfvc_pkg::QUAT_W-1:0] quat_w;
    logic signed [mfvc_pkg::QUAT_W-1:0] quat_x;
    logic signed [mfvc_pkg::QUAT_W-1:0] quat_y;
    logic signed [mfvc_pkg::QUAT_W-1:0] quat_z;
    modport source (output valid, mag_x, mag_y, mag_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink (input valid, mag_x, mag_y, mag_z, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface mfvc_out_if;
    logic       valid;
    logic       ready;
    logic       check_done;
    logic [1:0] alarm_action;
    modport source (output valid, check_done, alarm_action, input ready);
    modport sink (input valid, check_done, alarm_action, output ready);
endinterface
`default_nettype wire

/* hdl/mag_field_validity_check.sv */
// mag_field_validity_check: low-pass magnetometer averages and throttled field check
// one bit-serial shift-add multiplier for all products; depends on mfvc_pkg and mfvc_if
// each product passes the states load, multiply and write-back; a sample without a check
// runs only the three low-pass products, a sample with a check runs every product
// one sample at a time: a new sample is taken only after the result is loaded, later while a result stalls
// reset: averages, counters and streaks cleared, ratios 205 and 614, earth field zero
`default_nettype none
module mag_field_validity_check (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    mfvc_in_if.sink                        sample,
    mfvc_out_if.source                     result,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mfvc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mfvc_pkg::DATA_W-1:0] pwdata,
    output logic [mfvc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int FW  = mfvc_pkg::FIELD_WIDTH;
    localparam int AW  = mfvc_pkg::ACC_W;
    localparam int BW  = mfvc_pkg::B_W;
    localparam int DW  = mfvc_pkg::DEV_W;
    localparam int PW  = mfvc_pkg::PROD_W;
    localparam int RW  = mfvc_pkg::ROT_W;
    localparam int VW  = mfvc_pkg::AVG_W;
    localparam int LW  = mfvc_pkg::LPF_W;
    localparam int SW  = mfvc_pkg::SQ_W;
    localparam int QW  = mfvc_pkg::QUAT_W;
    localparam int TW  = mfvc_pkg::RATIO_W;
    localparam int R2W = mfvc_pkg::R2_W;
    localparam int CW  = mfvc_pkg::CNT_W;

    mfvc_pkg::state_t state_reg, state_next;
    mfvc_pkg::step_t  step_reg;

    logic signed [FW-1:0] be_north_reg, be_east_reg, be_down_reg;
    logic [TW-1:0] warn_ratio_reg, error_ratio_reg;

    logic signed [FW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [VW-1:0] avg_x_reg, avg_y_reg, avg_z_reg;
    logic [3:0] throttle_reg;
    logic [2:0] warn_streak_reg, error_streak_reg;

    logic signed [PW-1:0] prod_reg [10];
    logic signed [DW-1:0] ex_reg, ey_reg, ez_reg;
    logic [SW-1:0] e2_reg, d2_reg;
    logic [R2W-1:0] r2w_reg, r2e_reg;
    logic [AW-1:0] wthr_reg;

    logic signed [AW-1:0] a_reg, acc_reg;
    logic signed [BW-1:0] b_reg;
    logic [CW-1:0] cnt_reg, n_reg;

    logic pend_done_reg;
    mfvc_pkg::action_t pend_action_reg;
    logic out_valid_reg, out_done_reg;
    mfvc_pkg::action_t out_action_reg;

    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic [CW-1:0] op_n;
    logic op_clr;
    logic mul_last;
    logic in_fire, out_load;

    logic signed [RW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [VW-1:0] avg_sel;
    logic signed [FW-1:0] smp_sel;
    logic signed [LW-1:0] lpf_diff;
    logic signed [AW-1:0] lpf_sum, rot_sum;
    logic signed [DW-1:0] dx, dy, dz;
    logic w_lt, e_lt;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_north_reg    <= '0;
            be_east_reg     <= '0;
            be_down_reg     <= '0;
            warn_ratio_reg  <= mfvc_pkg::WARN_RATIO_RST;
            error_ratio_reg <= mfvc_pkg::ERROR_RATIO_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                mfvc_pkg::REG_BE_NORTH:    be_north_reg    <= $signed(pwdata[FW-1:0]);
                mfvc_pkg::REG_BE_EAST:     be_east_reg     <= $signed(pwdata[FW-1:0]);
                mfvc_pkg::REG_BE_DOWN:     be_down_reg     <= $signed(pwdata[FW-1:0]);
                mfvc_pkg::REG_WARN_RATIO:  warn_ratio_reg  <= pwdata[TW-1:0];
                mfvc_pkg::REG_ERROR_RATIO: error_ratio_reg <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            mfvc_pkg::REG_BE_NORTH:    prdata = 32'(be_north_reg);
            mfvc_pkg::REG_BE_EAST:     prdata = 32'(be_east_reg);
            mfvc_pkg::REG_BE_DOWN:     prdata = 32'(be_down_reg);
            mfvc_pkg::REG_WARN_RATIO:  prdata = 32'(warn_ratio_reg);
            mfvc_pkg::REG_ERROR_RATIO: prdata = 32'(error_ratio_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign sample.ready = (state_reg == mfvc_pkg::ST_IDLE);
    assign in_fire      = sample.valid && sample.ready;
    assign out_load     = (state_reg == mfvc_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    assign result.valid        = out_valid_reg;
    assign result.check_done   = out_done_reg;
    assign result.alarm_action = out_action_reg;

    // ---------------- operand selection ----------------
    assign r00 = RW'(prod_reg[0]) + RW'(prod_reg[1]) - RW'(prod_reg[2]) - RW'(prod_reg[3]);
    assign r11 = RW'(prod_reg[0]) - RW'(prod_reg[1]) + RW'(prod_reg[2]) - RW'(prod_reg[3]);
    assign r22 = RW'(prod_reg[0]) - RW'(prod_reg[1]) - RW'(prod_reg[2]) + RW'(prod_reg[3]);
    assign r01 = (RW'(prod_reg[4]) + RW'(prod_reg[5])) <<< 1;
    assign r10 = (RW'(prod_reg[4]) - RW'(prod_reg[5])) <<< 1;
    assign r02 = (RW'(prod_reg[6]) - RW'(prod_reg[7])) <<< 1;
    assign r20 = (RW'(prod_reg[6]) + RW'(prod_reg[7])) <<< 1;
    assign r12 = (RW'(prod_reg[8]) + RW'(prod_reg[9])) <<< 1;
    assign r21 = (RW'(prod_reg[8]) - RW'(prod_reg[9])) <<< 1;

    assign dx = ex_reg - DW'(avg_x_reg);
    assign dy = ey_reg - DW'(avg_y_reg);
    assign dz = ez_reg - DW'(avg_z_reg);

    always_comb
    begin
        unique case (step_reg)
            mfvc_pkg::S_LPF_X:
            begin
                avg_sel = avg_x_reg;
                smp_sel = sx_reg;
            end
            mfvc_pkg::S_LPF_Y:
            begin
                avg_sel = avg_y_reg;
                smp_sel = sy_reg;
            end
            default:
            begin
                avg_sel = avg_z_reg;
                smp_sel = sz_reg;
            end
        endcase
    end

    assign lpf_diff = (LW'(smp_sel) <<< 8) - LW'(avg_sel);
    assign lpf_sum  = (AW'(avg_sel) <<< 16) + acc_reg + AW'(32768);
    assign rot_sum  = acc_reg + AW'(524288);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_n   = mfvc_pkg::QUAT_N;
        op_clr = 1'b1;
        unique case (step_reg)
            mfvc_pkg::S_LPF_X, mfvc_pkg::S_LPF_Y, mfvc_pkg::S_LPF_Z:
            begin
                op_a = AW'(lpf_diff);
                op_b = BW'(mfvc_pkg::LPF_ALPHA);
                op_n = mfvc_pkg::LPF_N;
            end
            mfvc_pkg::S_Q_WW: begin op_a = AW'(qw_reg); op_b = BW'(qw_reg); end
            mfvc_pkg::S_Q_XX: begin op_a = AW'(qx_reg); op_b = BW'(qx_reg); end
            mfvc_pkg::S_Q_YY: begin op_a = AW'(qy_reg); op_b = BW'(qy_reg); end
            mfvc_pkg::S_Q_ZZ: begin op_a = AW'(qz_reg); op_b = BW'(qz_reg); end
            mfvc_pkg::S_Q_XY: begin op_a = AW'(qx_reg); op_b = BW'(qy_reg); end
            mfvc_pkg::S_Q_WZ: begin op_a = AW'(qw_reg); op_b = BW'(qz_reg); end
            mfvc_pkg::S_Q_XZ: begin op_a = AW'(qx_reg); op_b = BW'(qz_reg); end
            mfvc_pkg::S_Q_WY: begin op_a = AW'(qw_reg); op_b = BW'(qy_reg); end
            mfvc_pkg::S_Q_YZ: begin op_a = AW'(qy_reg); op_b = BW'(qz_reg); end
            mfvc_pkg::S_Q_WX: begin op_a = AW'(qw_reg); op_b = BW'(qx_reg); end
            mfvc_pkg::S_ROT_X0:
            begin
                op_a = AW'(r00); op_b = BW'(be_north_reg); op_n = mfvc_pkg::ROT_N;
            end
            mfvc_pkg::S_ROT_X1:
            begin
                op_a = AW'(r01); op_b = BW'(be_east_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_ROT_X2:
            begin
                op_a = AW'(r02); op_b = BW'(be_down_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_ROT_Y0:
            begin
                op_a = AW'(r10); op_b = BW'(be_north_reg); op_n = mfvc_pkg::ROT_N;
            end
            mfvc_pkg::S_ROT_Y1:
            begin
                op_a = AW'(r11); op_b = BW'(be_east_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_ROT_Y2:
            begin
                op_a = AW'(r12); op_b = BW'(be_down_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_ROT_Z0:
            begin
                op_a = AW'(r20); op_b = BW'(be_north_reg); op_n = mfvc_pkg::ROT_N;
            end
            mfvc_pkg::S_ROT_Z1:
            begin
                op_a = AW'(r21); op_b = BW'(be_east_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_ROT_Z2:
            begin
                op_a = AW'(r22); op_b = BW'(be_down_reg); op_n = mfvc_pkg::ROT_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_SQ_EX:
            begin
                op_a = AW'(ex_reg); op_b = BW'(ex_reg); op_n = mfvc_pkg::SQ_N;
            end
            mfvc_pkg::S_SQ_EY:
            begin
                op_a = AW'(ey_reg); op_b = BW'(ey_reg); op_n = mfvc_pkg::SQ_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_SQ_EZ:
            begin
                op_a = AW'(ez_reg); op_b = BW'(ez_reg); op_n = mfvc_pkg::SQ_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_SQ_DX:
            begin
                op_a = AW'(dx); op_b = BW'(dx); op_n = mfvc_pkg::SQ_N;
            end
            mfvc_pkg::S_SQ_DY:
            begin
                op_a = AW'(dy); op_b = BW'(dy); op_n = mfvc_pkg::SQ_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_SQ_DZ:
            begin
                op_a = AW'(dz); op_b = BW'(dz); op_n = mfvc_pkg::SQ_N;
                op_clr = 1'b0;
            end
            mfvc_pkg::S_R2_W:
            begin
                op_a = AW'(warn_ratio_reg); op_b = BW'(warn_ratio_reg);
                op_n = mfvc_pkg::R2_N;
            end
            mfvc_pkg::S_R2_E:
            begin
                op_a = AW'(error_ratio_reg); op_b = BW'(error_ratio_reg);
                op_n = mfvc_pkg::R2_N;
            end
            mfvc_pkg::S_THR_W:
            begin
                op_a = AW'(e2_reg); op_b = BW'(r2w_reg); op_n = mfvc_pkg::THR_N;
            end
            mfvc_pkg::S_THR_E:
            begin
                op_a = AW'(e2_reg); op_b = BW'(r2e_reg); op_n = mfvc_pkg::THR_N;
            end
            default: ;
        endcase
    end

    assign mul_last = (cnt_reg == n_reg - CW'(1));
    assign w_lt = (AW'({d2_reg, 24'd0}) < wthr_reg);
    assign e_lt = (AW'({d2_reg, 24'd0}) < AW'(acc_reg));

    // ---------------- state machine ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfvc_pkg::ST_IDLE: if (in_fire) state_next = mfvc_pkg::ST_LOAD;
            mfvc_pkg::ST_LOAD: state_next = mfvc_pkg::ST_MUL;
            mfvc_pkg::ST_MUL:  if (mul_last) state_next = mfvc_pkg::ST_WB;
            mfvc_pkg::ST_WB:
            begin
                if ((step_reg == mfvc_pkg::S_LPF_Z && throttle_reg != 4'd0)
                    || step_reg == mfvc_pkg::S_THR_E)
                begin
                    state_next = mfvc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = mfvc_pkg::ST_LOAD;
                end
            end
            mfvc_pkg::ST_DONE: if (out_load) state_next = mfvc_pkg::ST_IDLE;
            default: state_next = mfvc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= mfvc_pkg::S_LPF_X;
            cnt_reg          <= '0;
            avg_x_reg        <= '0;
            avg_y_reg        <= '0;
            avg_z_reg        <= '0;
            throttle_reg     <= '0;
            warn_streak_reg  <= '0;
            error_streak_reg <= '0;
            out_valid_reg    <= 1'b0;
            pend_done_reg    <= 1'b0;
            pend_action_reg  <= mfvc_pkg::ACT_NONE;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                mfvc_pkg::ST_IDLE: if (in_fire) step_reg <= mfvc_pkg::S_LPF_X;
                mfvc_pkg::ST_LOAD: cnt_reg <= '0;
                mfvc_pkg::ST_MUL:  cnt_reg <= cnt_reg + CW'(1);
                mfvc_pkg::ST_WB:
                begin
                    step_reg <= mfvc_pkg::step_t'(step_reg + 5'd1);
                    unique case (step_reg)
                        mfvc_pkg::S_LPF_X: avg_x_reg <= lpf_sum[VW+15:16];
                        mfvc_pkg::S_LPF_Y: avg_y_reg <= lpf_sum[VW+15:16];
                        mfvc_pkg::S_LPF_Z:
                        begin
                            avg_z_reg <= lpf_sum[VW+15:16];
                            if (throttle_reg != 4'd0)
                            begin
                                throttle_reg    <= throttle_reg - 4'd1;
                                pend_done_reg   <= 1'b0;
                                pend_action_reg <= mfvc_pkg::ACT_NONE;
                            end
                            else
                            begin
                                throttle_reg <= mfvc_pkg::CHECK_INTERVAL;
                            end
                        end
                        mfvc_pkg::S_THR_E:
                        begin
                            pend_done_reg <= 1'b1;
                            if (w_lt)
                            begin
                                warn_streak_reg  <= '0;
                                error_streak_reg <= '0;
                                pend_action_reg  <= mfvc_pkg::ACT_CLEAR;
                            end
                            else if (e_lt)
                            begin
                                error_streak_reg <= '0;
                                if (warn_streak_reg > mfvc_pkg::ALARM_PERSIST)
                                begin
                                    pend_action_reg <= mfvc_pkg::ACT_WARN;
                                end
                                else
                                begin
                                    warn_streak_reg <= warn_streak_reg + 3'd1;
                                    pend_action_reg <= mfvc_pkg::ACT_NONE;
                                end
                            end
                            else
                            begin
                                if (error_streak_reg > mfvc_pkg::ALARM_PERSIST)
                                begin
                                    pend_action_reg <= mfvc_pkg::ACT_ERROR;
                                end
                                else
                                begin
                                    error_streak_reg <= error_streak_reg + 3'd1;
                                    pend_action_reg  <= mfvc_pkg::ACT_NONE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                mfvc_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sx_reg <= sample.mag_x;
            sy_reg <= sample.mag_y;
            sz_reg <= sample.mag_z;
            qw_reg <= sample.quat_w;
            qx_reg <= sample.quat_x;
            qy_reg <= sample.quat_y;
            qz_reg <= sample.quat_z;
        end

        if (out_load)
        begin
            out_done_reg   <= pend_done_reg;
            out_action_reg <= pend_action_reg;
        end

        unique case (state_reg)
            mfvc_pkg::ST_LOAD:
            begin
                a_reg <= op_a;
                b_reg <= op_b;
                n_reg <= op_n;
                if (op_clr)
                begin
                    acc_reg <= '0;
                end
            end
            mfvc_pkg::ST_MUL:
            begin
                // shift-add, the top multiplier bit carries negative weight
                if (b_reg[0])
                begin
                    acc_reg <= mul_last ? acc_reg - a_reg : acc_reg + a_reg;
                end
                a_reg <= a_reg <<< 1;
                b_reg <= b_reg >>> 1;
            end
            mfvc_pkg::ST_WB:
            begin
                unique case (step_reg)
                    mfvc_pkg::S_Q_WW:   prod_reg[0] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_XX:   prod_reg[1] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_YY:   prod_reg[2] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_ZZ:   prod_reg[3] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_XY:   prod_reg[4] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_WZ:   prod_reg[5] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_XZ:   prod_reg[6] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_WY:   prod_reg[7] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_YZ:   prod_reg[8] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_Q_WX:   prod_reg[9] <= acc_reg[PW-1:0];
                    mfvc_pkg::S_ROT_X2: ex_reg <= rot_sum[DW+19:20];
                    mfvc_pkg::S_ROT_Y2: ey_reg <= rot_sum[DW+19:20];
                    mfvc_pkg::S_ROT_Z2: ez_reg <= rot_sum[DW+19:20];
                    mfvc_pkg::S_SQ_EZ:  e2_reg <= acc_reg[SW-1:0];
                    mfvc_pkg::S_SQ_DZ:  d2_reg <= acc_reg[SW-1:0];
                    mfvc_pkg::S_R2_W:   r2w_reg <= acc_reg[R2W-1:0];
                    mfvc_pkg::S_R2_E:   r2e_reg <= acc_reg[R2W-1:0];
                    mfvc_pkg::S_THR_W:  wthr_reg <= acc_reg;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
